/* rtl/ssdh_pkg.sv */
// Shared types and constants for the step/direction homing core.
package ssdh_pkg;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_SET_DEST = 2'd1,
        KIND_HOME     = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_STEPS_PER_POINT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POINTS_PER_STEP = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOME_STEP       = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FORWARD_DIR     = 2'd3;

    localparam logic [31:0] STEPS_PER_POINT_RST = 32'd65536;
    localparam logic [31:0] POINTS_PER_STEP_RST = 32'd65536;
    localparam logic [31:0] HOME_STEP_RST       = 32'd0;
    localparam logic        FORWARD_DIR_RST     = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    // Pin and status levels reported with every result
    typedef struct packed {
        logic dir;
        logic pulse;
        logic ready;
        logic homing;
    } motor_flags_t;

    localparam motor_flags_t FLAGS_RST = '{dir: 1'b0, pulse: 1'b0, ready: 1'b1, homing: 1'b0};

endpackage

/* rtl/ssdh_motion.sv */
// Next-state logic for one request: tick, destination conversion and homing.
module ssdh_motion
    import ssdh_pkg::*;
#(
    parameter int POS_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  kind_t                 kind,
    input  logic                  limit_n,
    input  logic                  tgt_neg,
    input  logic [63:0]           tgt_prod,
    input  logic [POS_WIDTH-1:0]  cur_pos,
    input  logic [POS_WIDTH-1:0]  dest_pos,
    input  motor_flags_t          flags_in,
    input  logic [31:0]           home_step,
    input  logic                  forward_dir,
    output logic [POS_WIDTH-1:0]  cur_next,
    output logic [POS_WIDTH-1:0]  dest_next,
    output motor_flags_t          flags_next
);

    logic [63:0]                 shifted;
    logic [63:0]                 lim64;
    logic                        conv_sat;
    logic [POS_WIDTH-1:0]        conv_mag;
    logic [POS_WIDTH-1:0]        conv_pos;
    logic [63:0]                 home64;
    logic [POS_WIDTH-1:0]        home_pos;
    logic                        home_gt0;
    logic signed [POS_WIDTH-1:0] c;
    logic signed [POS_WIDTH-1:0] d;

    // Point-to-step conversion: truncate toward zero, saturate to the count range
    assign shifted  = tgt_prod >> (2 * FRAC_BITS);
    assign lim64    = 64'd1 << (POS_WIDTH - 1);
    assign conv_sat = (shifted >= lim64);
    assign conv_mag = conv_sat ? lim64[POS_WIDTH-1:0] : shifted[POS_WIDTH-1:0];
    assign conv_pos = tgt_neg ? -conv_mag
                    : (conv_sat ? lim64[POS_WIDTH-1:0] - 1'b1 : conv_mag);

    assign home64   = {{32{home_step[31]}}, home_step};
    assign home_pos = home64[POS_WIDTH-1:0];
    assign home_gt0 = !home_step[31] && (home_step != 32'd0);

    always_comb begin
        cur_next   = cur_pos;
        dest_next  = dest_pos;
        flags_next = flags_in;
        c          = cur_pos;
        d          = dest_pos;
        case (kind)
            KIND_TICK: begin
                // Homing forces a one-step creep toward home until the switch closes
                if (flags_in.homing) begin
                    c = '0;
                    d = home_gt0 ? POS_WIDTH'(1) : {POS_WIDTH{1'b1}};
                    if (!limit_n) begin
                        flags_next.homing = 1'b0;
                        c = home_pos;
                        d = home_pos;
                    end
                end
                cur_next  = c;
                dest_next = d;
                if (c == d) begin
                    flags_next.ready = 1'b1;
                end else begin
                    flags_next.ready = 1'b0;
                    flags_next.dir   = (c > d) ? !forward_dir : forward_dir;
                    flags_next.pulse = !flags_in.pulse;
                    // Count moves on the falling pulse edge only
                    if (flags_in.pulse) begin
                        cur_next = (c > d) ? c - POS_WIDTH'(1) : c + POS_WIDTH'(1);
                    end
                end
            end
            KIND_SET_DEST: begin
                dest_next = conv_pos;
            end
            KIND_HOME: begin
                flags_next.homing = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/stepper_step_dir_homing_core.sv */
// Top level of the step/direction pulse generator with homing.
// A request reaches m_tvalid through six register stages: input, multiply, state,
// magnitude, split multiply and output.
// Throughput: one request per cycle while m_tready is high; each stage has its own valid
// bit, so bubbles absorb a stalled result and s_tready stays high while any stage is free.
// Reset (aresetn low, synchronous): position and destination 0, pulse and dir low,
// ready high, homing off, configuration to its defaults, pipeline empty.
module stepper_step_dir_homing_core
    import ssdh_pkg::*;
#(
    parameter int POS_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] target_point, [32] limit_n, rest zero
    input  logic [1:0]            s_tuser,   // [1:0] kind
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] dir_level, [1] pulse_level, [2] ready_res,
                                             // [3] homing, [35:4] position_steps,
                                             // [67:36] position_point, rest zero
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int HALF_W = 32;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] steps_per_point_reg;
    logic [31:0] points_per_step_reg;
    logic [31:0] home_step_reg;
    logic        forward_dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_per_point_reg <= STEPS_PER_POINT_RST;
            points_per_step_reg <= POINTS_PER_STEP_RST;
            home_step_reg       <= HOME_STEP_RST;
            forward_dir_reg     <= FORWARD_DIR_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_STEPS_PER_POINT: steps_per_point_reg <= cfg_wdata;
                CFG_POINTS_PER_STEP: points_per_step_reg <= cfg_wdata;
                CFG_HOME_STEP:       home_step_reg       <= cfg_wdata;
                CFG_FORWARD_DIR:     forward_dir_reg     <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and the ready chain (output backward)
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;
    assign m_tvalid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register; take the target magnitude on the way in
    // ------------------------------------------------------------------
    kind_t       kind0_reg;
    logic        limit0_reg;
    logic        neg0_reg;
    logic [31:0] mag0_reg;
    logic [31:0] s_target;

    assign s_target = s_tdata[31:0];

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            kind0_reg  <= kind_t'(s_tuser);
            limit0_reg <= s_tdata[32];
            neg0_reg   <= s_target[31];
            mag0_reg   <= s_target[31] ? -s_target : s_target;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: target magnitude times steps_per_point
    // ------------------------------------------------------------------
    kind_t       kind1_reg;
    logic        limit1_reg;
    logic        neg1_reg;
    logic [63:0] prod1_reg;
    logic [63:0] prod1_next;

    assign prod1_next = mag0_reg * steps_per_point_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            kind1_reg  <= kind0_reg;
            limit1_reg <= limit0_reg;
            neg1_reg   <= neg0_reg;
            prod1_reg  <= prod1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: motion state update, in request order
    // ------------------------------------------------------------------
    logic [POS_WIDTH-1:0] cur_pos_reg,  cur_pos_next;
    logic [POS_WIDTH-1:0] dest_pos_reg, dest_pos_next;
    motor_flags_t         flags_reg,    flags_next;
    logic                 state_adv;

    assign state_adv = v1_reg && rdy2;

    ssdh_motion #(
        .POS_WIDTH (POS_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_motion (
        .kind        (kind1_reg),
        .limit_n     (limit1_reg),
        .tgt_neg     (neg1_reg),
        .tgt_prod    (prod1_reg),
        .cur_pos     (cur_pos_reg),
        .dest_pos    (dest_pos_reg),
        .flags_in    (flags_reg),
        .home_step   (home_step_reg),
        .forward_dir (forward_dir_reg),
        .cur_next    (cur_pos_next),
        .dest_next   (dest_pos_next),
        .flags_next  (flags_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_pos_reg  <= '0;
            dest_pos_reg <= '0;
            flags_reg    <= FLAGS_RST;
        end else if (state_adv) begin
            cur_pos_reg  <= cur_pos_next;
            dest_pos_reg <= dest_pos_next;
            flags_reg    <= flags_next;
        end
    end

    // Snapshot of the updated state travels with the request
    motor_flags_t         flags2_reg;
    logic [POS_WIDTH-1:0] pos2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            flags2_reg <= flags_next;
            pos2_reg   <= cur_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sign, magnitude and reported step count
    // ------------------------------------------------------------------
    motor_flags_t         flags3_reg;
    logic [31:0]          steps3_reg;
    logic                 neg3_reg;
    logic [63:0]          mag3_reg;
    logic [63:0]          pos2_ext;
    logic [POS_WIDTH-1:0] pos2_mag;

    assign pos2_ext = {{(64 - POS_WIDTH){pos2_reg[POS_WIDTH-1]}}, pos2_reg};
    assign pos2_mag = pos2_reg[POS_WIDTH-1] ? -pos2_reg : pos2_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            flags3_reg <= flags2_reg;
            steps3_reg <= pos2_ext[31:0];
            neg3_reg   <= pos2_reg[POS_WIDTH-1];
            mag3_reg   <= 64'(pos2_mag);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitude times points_per_step, split in two halves
    // ------------------------------------------------------------------
    motor_flags_t flags4_reg;
    logic [31:0]  steps4_reg;
    logic         neg4_reg;
    logic [63:0]  hi4_reg, hi4_next;
    logic [63:0]  lo4_reg, lo4_next;

    assign hi4_next = mag3_reg[63:HALF_W] * points_per_step_reg;
    assign lo4_next = mag3_reg[HALF_W-1:0] * points_per_step_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            flags4_reg <= flags3_reg;
            steps4_reg <= steps3_reg;
            neg4_reg   <= neg3_reg;
            hi4_reg    <= hi4_next;
            lo4_reg    <= lo4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: combine halves, drop fraction, saturate to signed 32 bits
    // ------------------------------------------------------------------
    motor_flags_t flags5_reg;
    logic [31:0]  steps5_reg;
    logic [31:0]  point5_reg, point5_next;
    logic [63:0]  pt_sum;
    logic         pt_ovf;

    assign pt_sum = (hi4_reg << (HALF_W - FRAC_BITS)) + (lo4_reg >> FRAC_BITS);
    assign pt_ovf = (hi4_reg >= (64'd1 << FRAC_BITS)) || (pt_sum >= 64'h0000_0000_8000_0000);

    always_comb begin
        if (neg4_reg) begin
            point5_next = pt_ovf ? 32'h8000_0000 : -pt_sum[31:0];
        end else begin
            point5_next = pt_ovf ? 32'h7FFF_FFFF : pt_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            flags5_reg <= flags4_reg;
            steps5_reg <= steps4_reg;
            point5_reg <= point5_next;
        end
    end

    assign m_tdata = {4'd0, point5_reg, steps5_reg,
                      flags5_reg.homing, flags5_reg.ready, flags5_reg.pulse, flags5_reg.dir};

endmodule
